[rtl/wfha_pkg.sv]
// Package with shared widths, codes, the result word type and the saturating-add helper of the hole allocator.
`timescale 1ns / 1ps
`default_nettype none

package wfha_pkg;

  localparam int unsigned DEF_MAX_HOLES = 16;
  localparam int unsigned DEF_SIZE_BITS = 16;

  localparam int unsigned ITEM_SIZE_W = 16;
  localparam int unsigned HOLE_IDX_W  = 4;
  localparam int unsigned SPACE_W     = 16;
  localparam int unsigned REQ_NUM_W   = 16;
  localparam int unsigned SUM_W       = 32;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic                   load_accepted;
    logic                   allocated;
    logic [HOLE_IDX_W-1:0]  hole_index;
    logic [SPACE_W-1:0]     space_left;
    logic [REQ_NUM_W-1:0]   request_number;
    logic [SUM_W-1:0]       internal_frag_total;
    logic [SUM_W-1:0]       external_frag_total;
  } res_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/wfha_if.sv]
// Valid/ready channel interfaces for the input word and the result word.
`timescale 1ns / 1ps
`default_nettype none

interface wfha_in_if;
  import wfha_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [ITEM_SIZE_W-1:0] item_size;

  modport source (output valid, kind, item_size, input ready);
  modport sink   (input valid, kind, item_size, output ready);
endinterface

interface wfha_out_if;
  import wfha_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   load_accepted;
  logic                   allocated;
  logic [HOLE_IDX_W-1:0]  hole_index;
  logic [SPACE_W-1:0]     space_left;
  logic [REQ_NUM_W-1:0]   request_number;
  logic [SUM_W-1:0]       internal_frag_total;
  logic [SUM_W-1:0]       external_frag_total;

  modport source (output valid, load_accepted, allocated, hole_index, space_left,
                  request_number, internal_frag_total, external_frag_total,
                  input ready);
  modport sink   (input valid, load_accepted, allocated, hole_index, space_left,
                  request_number, internal_frag_total, external_frag_total,
                  output ready);
endinterface

`default_nettype wire

[rtl/worst_fit_hole_allocator.sv]
// Top level of the worst-fit hole allocator with its output register.
//
//   Channel | Dir | Word
//   in_i    | in  | kind, item_size
//   out_o   | out | load_accepted, allocated, hole_index, space_left,
//           |     | request_number, internal_frag_total, external_frag_total
//
// A request scans the hole table through its single read port, one entry a cycle.
// Reset clears the hole count, request counter and both totals; the table itself
// is not cleared, since only loaded entries are read.
// A finished result waits in the output register, so the next word is taken
// while the sink stalls; the sequencer holds its own result only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module worst_fit_hole_allocator import wfha_pkg::*; #(
  parameter int unsigned MAX_HOLES = DEF_MAX_HOLES,
  parameter int unsigned SIZE_BITS = DEF_SIZE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wfha_in_if.sink    in_i,
  wfha_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_HOLES);
  localparam int unsigned CNT_W = $clog2(MAX_HOLES + 1);

  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [SIZE_BITS-1:0] mem_rdata;
  logic                 out_valid_q;
  res_t                 out_q;

  wfha_ctrl #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  wfha_hole_mem #(
    .DEPTH  (MAX_HOLES),
    .WIDTH  (SIZE_BITS),
    .ADDR_W (IDX_W)
  ) u_hole_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.load_accepted       = out_q.load_accepted;
  assign out_o.allocated           = out_q.allocated;
  assign out_o.hole_index          = out_q.hole_index;
  assign out_o.space_left          = out_q.space_left;
  assign out_o.request_number      = out_q.request_number;
  assign out_o.internal_frag_total = out_q.internal_frag_total;
  assign out_o.external_frag_total = out_q.external_frag_total;

endmodule

`default_nettype wire

[rtl/wfha_hole_mem.sv]
// Hole size table: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module wfha_hole_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/wfha_ctrl.sv]
// Sequencer that loads holes, scans the table for the worst fit and updates the totals.
`timescale 1ns / 1ps
`default_nettype none

module wfha_ctrl import wfha_pkg::*; #(
  parameter int unsigned MAX_HOLES = DEF_MAX_HOLES,
  parameter int unsigned SIZE_BITS = DEF_SIZE_BITS,
  parameter int unsigned IDX_W     = $clog2(MAX_HOLES),
  parameter int unsigned CNT_W     = $clog2(MAX_HOLES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  wfha_in_if.sink              in_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output res_t                 res_o,
  output logic                 mem_we_o,
  output logic [IDX_W-1:0]     mem_waddr_o,
  output logic [SIZE_BITS-1:0] mem_wdata_o,
  output logic                 mem_re_o,
  output logic [IDX_W-1:0]     mem_raddr_o,
  input  logic [SIZE_BITS-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HOLES);

  state_e               state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [REQ_NUM_W-1:0] req_cnt_q;
  logic [SUM_W-1:0]     isum_q;
  logic [SUM_W-1:0]     esum_q;
  logic [SIZE_BITS-1:0] size_q;
  logic [CNT_W-1:0]     iss_q;
  logic                 pend_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 found_q;
  logic [SIZE_BITS-1:0] best_diff_q;
  logic [IDX_W-1:0]     best_idx_q;
  res_t                 res_q;

  logic                 accept;
  logic                 full;
  logic [SIZE_BITS-1:0] in_size;
  logic [SIZE_BITS-1:0] diff;
  logic                 better;
  logic                 load_we;
  logic                 upd_we;
  logic [SUM_W-1:0]     isum_d;
  logic [SUM_W-1:0]     esum_d;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign full        = (cnt_q == MAX_CNT);
  assign in_size     = SIZE_BITS'(in_i.item_size);

  assign mem_re_o    = (state_q == ST_SCAN) && (iss_q < cnt_q);
  assign mem_raddr_o = iss_q[IDX_W-1:0];

  assign load_we     = accept && (in_i.kind == KIND_LOAD) && !full;
  assign upd_we      = (state_q == ST_UPDATE) && found_q;
  assign mem_we_o    = load_we || upd_we;
  assign mem_waddr_o = upd_we ? best_idx_q : cnt_q[IDX_W-1:0];
  assign mem_wdata_o = upd_we ? best_diff_q : in_size;

  assign diff   = mem_rdata_i - size_q;
  assign better = pend_q && (mem_rdata_i >= size_q) && (!found_q || (diff > best_diff_q));

  assign isum_d = sat_add(isum_q, SUM_W'(best_diff_q));
  assign esum_d = sat_add(esum_q, SUM_W'(size_q));

  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      req_cnt_q   <= '0;
      isum_q      <= '0;
      esum_q      <= '0;
      size_q      <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      best_diff_q <= '0;
      best_idx_q  <= '0;
      res_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_q <= '{
              load_accepted:       load_we,
              allocated:           1'b0,
              hole_index:          load_we ? HOLE_IDX_W'(cnt_q) : '0,
              space_left:          '0,
              request_number:      (in_i.kind == KIND_LOAD) ? '0 : req_cnt_q,
              internal_frag_total: isum_q,
              external_frag_total: esum_q
            };
            if (in_i.kind == KIND_LOAD) begin
              if (!full) begin
                cnt_q <= cnt_q + 1'b1;
              end
              state_q <= ST_DONE;
            end else begin
              size_q    <= in_size;
              req_cnt_q <= req_cnt_q + 1'b1;
              iss_q     <= '0;
              pend_q    <= 1'b0;
              found_q   <= 1'b0;
              state_q   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_q    <= mem_re_o;
          cmp_idx_q <= iss_q[IDX_W-1:0];
          if (mem_re_o) begin
            iss_q <= iss_q + 1'b1;
          end
          if (better) begin
            found_q     <= 1'b1;
            best_diff_q <= diff;
            best_idx_q  <= cmp_idx_q;
          end
          if (!mem_re_o) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (found_q) begin
            isum_q                    <= isum_d;
            res_q.allocated           <= 1'b1;
            res_q.hole_index          <= HOLE_IDX_W'(best_idx_q);
            res_q.space_left          <= SPACE_W'(best_diff_q);
            res_q.internal_frag_total <= isum_d;
          end else begin
            esum_q                    <= esum_d;
            res_q.external_frag_total <= esum_d;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[verif/worst_fit_hole_allocator_tb.sv]
// Self-checking testbench of the worst-fit hole allocator with a predictor of its results.
`timescale 1ns / 1ps

module worst_fit_hole_allocator_tb;
  import wfha_pkg::*;

  localparam int unsigned SLOTS         = DEF_MAX_HOLES;
  localparam int unsigned RAND_PER_PHASE = 488;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam longint     CYCLE_LIMIT   = 64'd10_000_000;
  localparam logic [SUM_W-1:0] SUM_TOP  = {SUM_W{1'b1}};

  typedef struct packed {
    logic                   kind;
    logic [ITEM_SIZE_W-1:0] size;
    logic                   typed;
    res_t                   want;
  } dir_row_t;

  localparam res_t UNTYPED = '0;
  localparam int unsigned DIR_LEN = 25;

  // The first rows run on an empty table; the last loads find the table full.
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    '{KIND_REQUEST, 16'h0000, 1'b1, res_t'({1'b0, 1'b0, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0})},
    '{KIND_REQUEST, 16'hFFFF, 1'b1,
      res_t'({1'b0, 1'b0, 4'd0, 16'd0, 16'd1, 32'd0, 32'd65535})},
    '{KIND_LOAD, 16'hFFFF, 1'b1,
      res_t'({1'b1, 1'b0, 4'd0, 16'd0, 16'd0, 32'd0, 32'd65535})},
    '{KIND_LOAD, 16'h0000, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hFFFF, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hFFFF, 1'b0, UNTYPED},
    '{KIND_REQUEST, 16'h0000, 1'b0, UNTYPED},
    '{KIND_REQUEST, 16'hFFFF, 1'b0, UNTYPED},
    '{KIND_REQUEST, 16'hFFFF, 1'b0, UNTYPED},
    '{KIND_REQUEST, 16'hFFFF, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'h5555, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hAAAA, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'h00FF, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hFF00, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'h8000, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'h7FFF, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'h0001, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hFFFE, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'h1234, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'h0F0F, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hF0F0, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hFFFF, 1'b0, UNTYPED},
    '{KIND_LOAD, 16'hFFFF, 1'b1,
      res_t'({1'b0, 1'b0, 4'd0, 16'd0, 16'd0, 32'd65535, 32'd65535})},
    '{KIND_LOAD, 16'h0000, 1'b1,
      res_t'({1'b0, 1'b0, 4'd0, 16'd0, 16'd0, 32'd65535, 32'd65535})},
    '{KIND_REQUEST, 16'h8000, 1'b0, UNTYPED}
  };

  logic clk;
  logic rst_n;

  wfha_in_if  in_if ();
  wfha_out_if out_if ();

  worst_fit_hole_allocator u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [ITEM_SIZE_W-1:0] model_holes [SLOTS];
  int unsigned            model_hole_cnt;
  logic [REQ_NUM_W-1:0]   model_req_num;
  logic [SUM_W-1:0]       model_int_frag;
  logic [SUM_W-1:0]       model_ext_frag;

  res_t   alloc_results_q [$];
  int     mismatch_count;
  int     tx_idle_pct;
  int     rx_stall_pct;
  int     rx_hold_cycles;
  longint cycle_count;
  res_t   got_res;
  res_t   want_res;

  int                     row;
  int                     n;
  int                     phase;
  int                     pick;
  logic                   rand_kind;
  logic [ITEM_SIZE_W-1:0] rand_size;
  logic [ITEM_SIZE_W-1:0] biggest;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [SUM_W-1:0] clip_add(input logic [SUM_W-1:0] acc,
                                                input logic [SUM_W-1:0] inc);
    return (acc > SUM_TOP - inc) ? SUM_TOP : acc + inc;
  endfunction

  // Applies one word to the model state and returns the result word it produces.
  function automatic res_t alloc_result(input logic kind, input logic [ITEM_SIZE_W-1:0] size);
    res_t                  r;
    logic                  found;
    logic [SPACE_W-1:0]    best_left;
    logic [HOLE_IDX_W-1:0] best_idx;
    r         = '0;
    found     = 1'b0;
    best_left = '0;
    best_idx  = '0;
    if (kind == KIND_LOAD) begin
      if (model_hole_cnt < SLOTS) begin
        model_holes[model_hole_cnt] = size;
        r.load_accepted = 1'b1;
        r.hole_index    = model_hole_cnt[HOLE_IDX_W-1:0];
        model_hole_cnt++;
      end
    end else begin
      r.request_number = model_req_num;
      model_req_num    = model_req_num + 1'b1;
      for (int j = 0; j < model_hole_cnt; j++) begin
        if (model_holes[j] >= size && (!found || model_holes[j] - size > best_left)) begin
          found     = 1'b1;
          best_left = model_holes[j] - size;
          best_idx  = j[HOLE_IDX_W-1:0];
        end
      end
      if (found) begin
        model_holes[best_idx] = best_left;
        model_int_frag        = clip_add(model_int_frag, SUM_W'(best_left));
        r.allocated           = 1'b1;
        r.hole_index          = best_idx;
        r.space_left          = best_left;
      end else begin
        model_ext_frag = clip_add(model_ext_frag, SUM_W'(size));
      end
    end
    r.internal_frag_total = model_int_frag;
    r.external_frag_total = model_ext_frag;
    return r;
  endfunction

  task automatic send_word(input logic kind, input logic [ITEM_SIZE_W-1:0] size,
                           input logic typed, input res_t want);
    res_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.item_size <= size;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    predicted = alloc_result(kind, size);
    alloc_results_q.insert(alloc_results_q.size(), typed ? want : predicted);
  endtask

  task automatic settle_all();
    in_if.valid <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [SUM_W-1:0] want,
                              input logic [SUM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got_res = '{out_if.load_accepted, out_if.allocated, out_if.hole_index,
                  out_if.space_left, out_if.request_number,
                  out_if.internal_frag_total, out_if.external_frag_total};
      if (alloc_results_q.size() == 0) begin
        $display("%0t: result word with none expected, expected none got %h", $time, got_res);
        mismatch_count++;
      end else begin
        want_res = alloc_results_q.pop_front();
        report_field("load_accepted", SUM_W'(want_res.load_accepted),
                     SUM_W'(got_res.load_accepted));
        report_field("allocated", SUM_W'(want_res.allocated), SUM_W'(got_res.allocated));
        report_field("hole_index", SUM_W'(want_res.hole_index), SUM_W'(got_res.hole_index));
        report_field("space_left", SUM_W'(want_res.space_left), SUM_W'(got_res.space_left));
        report_field("request_number", SUM_W'(want_res.request_number),
                     SUM_W'(got_res.request_number));
        report_field("internal_frag_total", want_res.internal_frag_total,
                     got_res.internal_frag_total);
        report_field("external_frag_total", want_res.external_frag_total,
                     got_res.external_frag_total);
      end
    end
    if (rx_hold_cycles > 0) rx_hold_cycles--;
    out_if.ready <= (rx_hold_cycles == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_LOAD;
    in_if.item_size = '0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    rx_hold_cycles  = 0;
    model_hole_cnt  = 0;
    model_req_num   = '0;
    model_int_frag  = '0;
    model_ext_frag  = '0;
    for (int k = 0; k < SLOTS; k++) model_holes[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < DIR_LEN; row++) begin
      send_word(DIR_ROWS[row].kind, DIR_ROWS[row].size, DIR_ROWS[row].typed,
                DIR_ROWS[row].want);
    end
    settle_all();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct    = 0;
          rx_stall_pct   = 0;
          rx_hold_cycles = HOLD_CYCLES;
        end
        1: begin
          tx_idle_pct  = 83;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 83;
        end
        default: begin
          tx_idle_pct  = 33;
          rx_stall_pct = 33;
        end
      endcase
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        biggest = '0;
        for (int k = 0; k < model_hole_cnt; k++) begin
          if (model_holes[k] > biggest) biggest = model_holes[k];
        end
        pick      = $urandom_range(99);
        rand_kind = (pick < 10) ? KIND_LOAD : KIND_REQUEST;
        pick      = $urandom_range(99);
        if (rand_kind == KIND_LOAD || pick < 14) begin
          rand_size = ITEM_SIZE_W'($urandom_range(65535));
        end else if (pick < 22) begin
          rand_size = '0;
        end else if (pick < 27) begin
          rand_size = model_holes[$urandom_range(model_hole_cnt - 1)];
        end else begin
          rand_size = biggest >> $urandom_range(8, 1);
        end
        send_word(rand_kind, rand_size, 1'b0, UNTYPED);
      end
      settle_all();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wfha_pkg.sv
rtl/wfha_if.sv
rtl/wfha_hole_mem.sv
rtl/wfha_ctrl.sv
rtl/worst_fit_hole_allocator.sv
verif/worst_fit_hole_allocator_tb.sv
